// ===== src/tcw_pkg.sv =====
package tcw_pkg;

  localparam int NUM_COLS  = 80;
  localparam int NUM_ROWS  = 25;
  localparam int NUM_CELLS = NUM_COLS * NUM_ROWS;
  localparam int ADDR_W    = $clog2(NUM_CELLS);
  localparam int COPY_CELLS = NUM_CELLS - NUM_COLS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam logic [7:0] CURSOR_ATTR  = 8'h0f;
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_POKE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

endpackage

// ===== src/text_console_writer.sv =====
// Flow: an accepted item goes to S_EXEC; put-char and put-at then write the cell in
// S_WRITE, a read waits for the registered RAM read in S_RDWAIT, and a newline that does
// not scroll or an off-screen position goes to S_RESP, which holds until the output
// register is free; only then is the next item taken. A scroll reads then writes each
// cell; a clear sweeps all NUM_CELLS cells. Reset is synchronous, active low; after reset
// a clearing pass over all NUM_CELLS cells zeroes the screen RAM while in_ready stays low.
module text_console_writer import tcw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  input  logic [7:0]       in_ch,
  input  logic [7:0]       in_color,
  input  logic [COL_W-1:0] in_col,
  input  logic [ROW_W-1:0] in_row,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [COL_W-1:0] out_cursor_col,
  output logic [ROW_W-1:0] out_cursor_row,
  output logic [7:0]       out_cell_char,
  output logic [7:0]       out_cell_color
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WRITE,
    S_RDWAIT,
    S_SCR_RD,
    S_SCR_WR,
    S_CLR,
    S_RESP
  } state_t;

  state_t            state_r;
  logic              init_r;     // clearing pass after reset, no result owed
  logic [ADDR_W-1:0] cnt_r;      // sweep index for clear and scroll

  // latched item
  op_t               op_r;
  logic [7:0]        ch_r;
  logic [7:0]        color_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;

  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [7:0]        cell_char_r;
  logic [7:0]        cell_color_r;

  // output register
  logic              out_valid_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [7:0]        out_char_r;
  logic [7:0]        out_color_r;

  ram_wr_t           wr;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;

  logic [COL_W-1:0]  a_col;
  logic [ROW_W-1:0]  a_row;
  logic [ADDR_W-1:0] cell_addr;
  logic              pos_ok;
  logic              is_nl;
  logic              wrap;
  logic              last_row;
  logic              sweep_done;

  // Shared address unit: row * NUM_COLS + col, for the cursor on put-char and for the
  // item position on put-at and read.
  always_comb begin
    a_col     = (op_r == OP_PUT) ? cur_col_r : col_r;
    a_row     = (op_r == OP_PUT) ? cur_row_r : row_r;
    cell_addr = ADDR_W'(ADDR_W'(a_row) * ADDR_W'(NUM_COLS)) + ADDR_W'(a_col);
  end

  assign pos_ok     = (col_r < COL_W'(NUM_COLS)) && (row_r < ROW_W'(NUM_ROWS));
  assign is_nl      = (ch_r == NEWLINE_CHAR);
  // wrap: a newline, or a pending wrap with the column one past the last column
  assign wrap       = is_nl || (cur_col_r >= COL_W'(NUM_COLS));
  assign last_row   = (cur_row_r == ROW_W'(NUM_ROWS - 1));
  assign sweep_done = (cnt_r == ADDR_W'(NUM_CELLS - 1));

  // Read address: source row of the scroll copy, otherwise the addressed cell.
  assign raddr = (state_r == S_SCR_RD) ? (cnt_r + ADDR_W'(NUM_COLS)) : cell_addr;

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = cnt_r;
    wr.data = '0;
    case (state_r)
      S_CLR: begin
        wr.en = 1'b1;
      end
      S_SCR_WR: begin
        wr.en = 1'b1;
        // bottom row gets zeros, the rest moves up one row
        wr.data = (cnt_r >= ADDR_W'(COPY_CELLS)) ? '0 : rdata;
      end
      S_WRITE: begin
        wr.en   = 1'b1;
        wr.addr = cell_addr;
        wr.data = (op_r == OP_PUT) ? {CURSOR_ATTR, ch_r} : {color_r, ch_r};
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  tcw_screen_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      init_r      <= 1'b1;
      cnt_r       <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a new result when the output register is free, drop the old one once
      // the consumer takes it
      if (state_r == S_RESP && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= op_t'(in_op);
            ch_r    <= in_ch;
            color_r <= in_color;
            col_r   <= in_col;
            row_r   <= in_row;
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          cell_char_r  <= '0;
          cell_color_r <= '0;
          case (op_r)
            OP_PUT: begin
              if (wrap) begin
                cur_col_r <= '0;
                if (last_row) begin
                  cnt_r   <= '0;
                  state_r <= S_SCR_RD;
                end else begin
                  cur_row_r <= cur_row_r + 1'b1;
                  state_r   <= is_nl ? S_RESP : S_WRITE;
                end
              end else begin
                state_r <= S_WRITE;
              end
            end
            OP_POKE: begin
              state_r <= pos_ok ? S_WRITE : S_RESP;
            end
            OP_CLEAR: begin
              cur_col_r <= '0;
              cur_row_r <= '0;
              cnt_r     <= '0;
              state_r   <= S_CLR;
            end
            OP_READ: begin
              // RAM read issued this cycle at the item position
              state_r <= pos_ok ? S_RDWAIT : S_RESP;
            end
            default: begin
              state_r <= S_RESP;
            end
          endcase
        end

        S_WRITE: begin
          // advance the cursor after a put-char
          if (op_r == OP_PUT) begin
            cur_col_r <= cur_col_r + 1'b1;
          end
          state_r <= S_RESP;
        end

        S_RDWAIT: begin
          cell_char_r  <= rdata[7:0];
          cell_color_r <= rdata[15:8];
          state_r      <= S_RESP;
        end

        S_SCR_RD: begin
          state_r <= S_SCR_WR;
        end

        S_SCR_WR: begin
          if (sweep_done) begin
            state_r <= is_nl ? S_RESP : S_WRITE;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_SCR_RD;
          end
        end

        S_CLR: begin
          if (sweep_done) begin
            init_r  <= 1'b0;
            state_r <= init_r ? S_IDLE : S_RESP;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        S_RESP: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_col_r   <= cur_col_r;
            out_row_r   <= cur_row_r;
            out_char_r  <= cell_char_r;
            out_color_r <= cell_color_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_color = out_color_r;

endmodule

// ===== src/tcw_screen_ram.sv =====
module tcw_screen_ram import tcw_pkg::*; (
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [NUM_CELLS];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tcw_checker.sv =====
module tcw_checker import tcw_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [COL_W-1:0] out_cursor_col,
  input logic [ROW_W-1:0] out_cursor_row,
  input logic [7:0]       out_cell_char,
  input logic [7:0]       out_cell_color
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_col) &&
      $stable(out_cursor_row) && $stable(out_cell_char) && $stable(out_cell_color))
    else $error("result changed while stalled");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_col <= COL_W'(NUM_COLS)) &&
      (out_cursor_row < ROW_W'(NUM_ROWS)))
    else $error("cursor out of range");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transfer");

  // no input while the screen is cleared after reset
  a_init_busy: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("ready during the clearing pass");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_cursor_col (out_cursor_col),
  .out_cursor_row (out_cursor_row),
  .out_cell_char  (out_cell_char),
  .out_cell_color (out_cell_color)
);

// ===== verif/text_console_writer_tb.sv =====
module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  // Drop the run if it overruns. Budgeted from a run where every character
  // scrolls the screen (a read and a write per RAM cell), with both sides at
  // their longest waits, taken several times over.
  localparam int LIMIT_NS      = 60_000_000;
  localparam int ITEM_TARGET   = 1750;
  localparam int SETTLE_CYCLES = 8;

  // One status word as the console reports it.
  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0]       cell_char;
    logic [7:0]       cell_color;
  } console_status_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       in_op;
  logic [7:0]       in_ch;
  logic [7:0]       in_color;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic             out_valid;
  logic             out_ready;
  logic [COL_W-1:0] out_cursor_col;
  logic [ROW_W-1:0] out_cursor_row;
  logic [7:0]       out_cell_char;
  logic [7:0]       out_cell_color;

  // Shadow of the screen and cursor, advanced once per accepted transfer.
  logic [CELL_W-1:0] screen_mem [NUM_CELLS];
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;

  // Status words still owed by the console, oldest first.
  console_status_t status_q [$];

  // Idle controls: when set, the side draws a random idle gap before each transfer.
  bit tx_idle;
  bit rx_idle;
  // Request for one long output stall; the result sink takes it as its next wait and clears it.
  int rx_hold_cycles;

  int items_sent;
  int results_checked;
  int fail_count;
  int chars_written;
  int scrolls_predicted;
  int clears_predicted;
  int reads_predicted;

  text_console_writer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_ch          (in_ch),
    .in_color       (in_color),
    .in_col         (in_col),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_char  (out_cell_char),
    .out_cell_color (out_cell_color)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the console hangs.
  initial begin
    #(LIMIT_NS);
    $display("text_console_writer test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: apply one command to the shadow screen and return the status
  // word the console must answer with.
  // ---------------------------------------------------------------------------
  function automatic console_status_t console_apply(input op_t op, input logic [7:0] ch,
                                                    input logic [7:0] color,
                                                    input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
    console_status_t res;
    int idx;
    res = '0;
    case (op)
      OP_PUT: begin
        // A newline, or any character while a wrap is pending, moves to the
        // start of the next line first; past the last line the screen scrolls.
        if (ch == NEWLINE_CHAR || cur_col >= NUM_COLS) begin
          cur_col = '0;
          if (int'(cur_row) + 1 >= NUM_ROWS) begin
            for (int i = 0; i < NUM_CELLS - NUM_COLS; i++)
              screen_mem[i] = screen_mem[i + NUM_COLS];
            for (int i = NUM_CELLS - NUM_COLS; i < NUM_CELLS; i++)
              screen_mem[i] = '0;
            scrolls_predicted++;
          end else begin
            cur_row = cur_row + 1'b1;
          end
        end
        // The newline itself leaves no mark on the screen.
        if (ch != NEWLINE_CHAR) begin
          idx = int'(cur_row) * NUM_COLS + int'(cur_col);
          screen_mem[idx] = {CURSOR_ATTR, ch};
          cur_col = cur_col + 1'b1;
          chars_written++;
        end
      end
      OP_POKE: begin
        // Positions off the screen are dropped silently.
        if (col < NUM_COLS && row < NUM_ROWS) begin
          idx = int'(row) * NUM_COLS + int'(col);
          screen_mem[idx] = {color, ch};
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NUM_CELLS; i++)
          screen_mem[i] = '0;
        cur_col = '0;
        cur_row = '0;
        clears_predicted++;
      end
      default: begin
        // Off-screen reads return an empty cell.
        if (col < NUM_COLS && row < NUM_ROWS) begin
          idx = int'(row) * NUM_COLS + int'(col);
          res.cell_char  = screen_mem[idx][7:0];
          res.cell_color = screen_mem[idx][15:8];
        end
        reads_predicted++;
      end
    endcase
    res.cursor_col = cur_col;
    res.cursor_row = cur_row;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: offer one command and hold it until the transfer. Entered and
  // left at a falling edge, so each step sees at most one update per signal.
  // ---------------------------------------------------------------------------
  task automatic send_item(input op_t op, input logic [7:0] ch, input logic [7:0] color,
                           input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    int gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op    <= op;
    in_ch    <= ch;
    in_color <= color;
    in_col   <= col;
    in_row   <= row;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_ready === 1'b1));
    status_q.push_back(console_apply(op, ch, color, col, row));
    items_sent++;
    @(negedge clk);
  endtask

  // Character at the cursor; the other fields are don't-care and get noise.
  task automatic put_char(input logic [7:0] ch);
    send_item(OP_PUT, ch, 8'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
              ROW_W'($urandom_range(0, 31)));
  endtask

  task automatic read_cell(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    send_item(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), col, row);
  endtask

  // Any printable-or-not byte except the newline.
  function automatic logic [7:0] rand_glyph();
    logic [7:0] g;
    do g = 8'($urandom_range(0, 255)); while (g == NEWLINE_CHAR);
    return g;
  endfunction

  // Drop valid and hold until every owed status word is back, then let anything
  // still in the pipe settle.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: per status word draw a wait, then raise ready until the
  // transfer. A pending long hold replaces the next draw.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = rx_idle ? $urandom_range(0, 5) : 0;
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
    end
  end

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t ns: status %0d %s mismatch, expected %0d got %0d",
                 $realtime, results_checked, name, want_v, got_v);
    end
  endtask

  // Compare every status transfer against the oldest owed word.
  always @(posedge clk) begin : status_check
    console_status_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (status_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t ns: status transfer with nothing outstanding", $realtime);
      end else begin
        want = status_q.pop_front();
        check_field("cursor_col", 8'(want.cursor_col), 8'(out_cursor_col));
        check_field("cursor_row", 8'(want.cursor_row), 8'(out_cursor_row));
        check_field("cell_char", want.cell_char, out_cell_char);
        check_field("cell_color", want.cell_color, out_cell_color);
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every command, newline, off-screen writes and reads.
  task automatic test_directed();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    read_cell(0, 0);                 // fresh screen reads back empty
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hff);
    put_char(NEWLINE_CHAR);          // cursor moves, nothing written
    read_cell(0, 1);
    read_cell(2, 0);
    send_item(OP_POKE, 8'hff, 8'hff, COL_W'(NUM_COLS - 1), ROW_W'(NUM_ROWS - 1));
    send_item(OP_POKE, 8'h00, 8'h00, 0, 0);
    send_item(OP_POKE, 8'h5a, 8'ha5, COL_W'(NUM_COLS), 0);   // one column off the edge
    send_item(OP_POKE, 8'h5a, 8'ha5, 0, ROW_W'(NUM_ROWS));   // one row off the edge
    send_item(OP_POKE, 8'h3c, 8'hc3, 7'h7f, 5'h1f);
    send_item(OP_POKE, 8'h66, 8'h99, 7'd64, 5'd16);          // top bits of col and row
    read_cell(COL_W'(NUM_COLS - 1), ROW_W'(NUM_ROWS - 1));
    read_cell(0, 0);
    read_cell(COL_W'(NUM_COLS), 0);
    read_cell(0, ROW_W'(NUM_ROWS));
    read_cell(7'h7f, 5'h1f);
    read_cell(7'd64, 5'd16);
    read_cell(1, 0);
    send_item(OP_CLEAR, 8'hff, 8'hff, 7'h7f, 5'h1f);
    read_cell(COL_W'(NUM_COLS - 1), ROW_W'(NUM_ROWS - 1));
    read_cell(7'd64, 5'd16);
  endtask

  // Line wrap, newline on a pending wrap, and scrolling by newline and by wrap.
  task automatic test_wrap_and_scroll();
    int n;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_item(OP_CLEAR, 8'h00, 8'h00, 0, 0);
    // fill a whole line: cursor parks one past the last column
    repeat (NUM_COLS) put_char(rand_glyph());
    // newline on a pending wrap advances one line only
    put_char(NEWLINE_CHAR);
    // run off the end of a line and let the character wrap it
    repeat (NUM_COLS + 3) put_char(rand_glyph());
    // walk past the bottom so the screen scrolls a few times
    for (int r = 0; r < NUM_ROWS + 3; r++) begin
      n = $urandom_range(0, 6);
      repeat (n) put_char(rand_glyph());
      put_char(NEWLINE_CHAR);
    end
    // a full bottom line plus one more: scroll caused by the wrap
    repeat (NUM_COLS + 1) put_char(rand_glyph());
    repeat (12) read_cell(COL_W'($urandom_range(0, NUM_COLS - 1)),
                          ROW_W'($urandom_range(0, NUM_ROWS - 1)));
    for (int c = 0; c < 8; c++) begin
      read_cell(COL_W'(c), ROW_W'(NUM_ROWS - 1));
      read_cell(COL_W'(c), ROW_W'(NUM_ROWS - 2));
    end
  endtask

  // Stall the output for a long stretch while commands keep coming, so the
  // console backs up and drops in_ready; then hold the input until it drains.
  task automatic test_output_stall();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 400;
    repeat (40) begin
      if ($urandom_range(0, 2) == 0)
        read_cell(COL_W'($urandom_range(0, NUM_COLS - 1)), cur_row);
      else
        put_char(rand_glyph());
    end
    wait_drain();
  endtask

  // Mostly text bursts with newlines, plus read sweeps, pokes, rare clears and
  // some raw noise. Idling is redrawn per burst so quiet stretches occur too.
  task automatic test_random_traffic();
    int kind;
    int len;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    while (items_sent < ITEM_TARGET) begin
      kind    = $urandom_range(0, 99);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (kind < 45) begin
        len = $urandom_range(1, 40);
        repeat (len)
          put_char(($urandom_range(0, 11) == 0) ? NEWLINE_CHAR : 8'($urandom_range(0, 255)));
      end else if (kind < 70) begin
        len = $urandom_range(1, 12);
        repeat (len) begin
          if ($urandom_range(0, 5) == 0) begin
            c = COL_W'($urandom_range(0, 127));
            r = ROW_W'($urandom_range(0, 31));
          end else begin
            c = COL_W'($urandom_range(0, NUM_COLS - 1));
            r = ($urandom_range(0, 1) == 0) ? cur_row : ROW_W'($urandom_range(0, NUM_ROWS - 1));
          end
          read_cell(c, r);
        end
      end else if (kind < 90) begin
        len = $urandom_range(1, 10);
        repeat (len) begin
          if ($urandom_range(0, 4) == 0) begin
            c = COL_W'($urandom_range(0, 127));
            r = ROW_W'($urandom_range(0, 31));
          end else begin
            c = COL_W'($urandom_range(0, NUM_COLS - 1));
            r = ROW_W'($urandom_range(0, NUM_ROWS - 1));
          end
          send_item(OP_POKE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), c, r);
        end
      end else if (kind < 95) begin
        send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
      end else begin
        len = $urandom_range(1, 5);
        repeat (len)
          send_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
                    ROW_W'($urandom_range(0, 31)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_op    = '0;
    in_ch    = '0;
    in_color = '0;
    in_col   = '0;
    in_row   = '0;
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    rx_hold_cycles = 0;
    for (int i = 0; i < NUM_CELLS; i++)
      screen_mem[i] = '0;
    cur_col = '0;
    cur_row = '0;

    // Hold reset, then release at a falling edge. The console sweeps its RAM
    // clean before taking commands; send_item just waits that out.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    wait_drain();
    test_wrap_and_scroll();
    wait_drain();
    test_output_stall();
    test_random_traffic();
    wait_drain();

    $display("Ran %0d commands: %0d characters written, %0d scrolls, %0d clears, %0d reads.",
             items_sent, chars_written, scrolls_predicted, clears_predicted, reads_predicted);
    $display("Checked %0d status words; %0d field errors or stray words.",
             results_checked, fail_count);
    if (fail_count == 0 && status_q.size() == 0) begin
      $display("text_console_writer test passed");
    end else begin
      $display("text_console_writer test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tcw_pkg.sv
src/tcw_screen_ram.sv
src/text_console_writer.sv
src/tcw_checker.sv
verif/text_console_writer_tb.sv
